>>> hdl/cdad_pkg.sv
// ----------------------------------------------------------------------------
// Date arithmetic package
// Shared types, constants and the month length table for the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 16;
    // Working day count: largest start day plus largest day count.
    localparam int ACC_W   = 17;
    // Year modulo 400 and the quotient of year by 400.
    localparam int YMOD_W  = 9;
    localparam int QUOT_W  = 6;
    localparam int PROD_W  = 27;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [MONTH_W-1:0] C_MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] C_MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] C_MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0] C_YEAR_MAX   = 14'h3FFF;
    localparam logic [YMOD_W-1:0] C_YMOD_100   = 9'd100;
    localparam logic [YMOD_W-1:0] C_YMOD_200   = 9'd200;
    localparam logic [YMOD_W-1:0] C_YMOD_300   = 9'd300;
    localparam logic [YMOD_W-1:0] C_YMOD_LAST  = 9'd399;
    localparam logic [YEAR_W-1:0] C_CYCLE_LEN  = 14'd400;

    // floor(y / 400) = (y * 5243) >> 21, exact for every 14-bit year.
    localparam logic [12:0] C_DIV400_MUL   = 13'd5243;
    localparam int          C_DIV400_SHIFT = 21;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

    function automatic logic [DAY_W-1:0] f_month_len(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            case (month) inside
                C_MONTH_FEB:             len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

>>> hdl/cdad_ctrl.sv
// ----------------------------------------------------------------------------
// Date adder controller
// Sequences load, year-cycle preparation and the month loop, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module cdad_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  cdad_pkg::t_sts i_sts,
    output cdad_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_out_free;

    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.prep = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.commit) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // A result may only overwrite the output register once it has been taken.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_ovalid || i_m_tready))
        else $error("result written over an item still waiting");

    a_no_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_sts.done)
        else $error("month step issued after the date was settled");

    a_load_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_cmd.prep)
        else $error("accepted item not followed by preparation");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(o_cmd.commit))
        else $error("output valid raised without a commit");

endmodule

>>> hdl/cdad_dp.sv
// ----------------------------------------------------------------------------
// Date adder datapath
// Holds the working date, walks one month per step and keeps the result
// register.
// ----------------------------------------------------------------------------
module cdad_dp (
    input  logic                             i_clk,
    input  cdad_pkg::t_cmd                   i_cmd,
    output cdad_pkg::t_sts                   o_sts,
    input  logic [cdad_pkg::YEAR_W-1:0]      i_start_year,
    input  logic [cdad_pkg::MONTH_W-1:0]     i_start_month,
    input  logic [cdad_pkg::DAY_W-1:0]       i_start_day,
    input  logic [cdad_pkg::ADD_W-1:0]       i_add_days,
    output logic [cdad_pkg::YEAR_W-1:0]      o_end_year,
    output logic [cdad_pkg::MONTH_W-1:0]     o_end_month,
    output logic [cdad_pkg::DAY_W-1:0]       o_end_day,
    output logic                             o_bad_input
);

    logic [cdad_pkg::YEAR_W-1:0]  r_year;
    logic [cdad_pkg::MONTH_W-1:0] r_month;
    logic [cdad_pkg::ACC_W-1:0]   r_day;
    logic                         r_bad;
    logic [cdad_pkg::QUOT_W-1:0]  r_quot;
    logic [cdad_pkg::YMOD_W-1:0]  r_ymod;

    logic [cdad_pkg::PROD_W-1:0]  w_prod;
    logic [cdad_pkg::YEAR_W-1:0]  w_rem;
    logic                         w_bad_in;
    logic                         w_leap;
    logic [cdad_pkg::DAY_W-1:0]   w_len;
    logic [cdad_pkg::ACC_W-1:0]   w_sum;

    assign w_prod = cdad_pkg::PROD_W'(i_start_year)
                  * cdad_pkg::PROD_W'(cdad_pkg::C_DIV400_MUL);
    assign w_rem  = r_year
                  - cdad_pkg::YEAR_W'(cdad_pkg::YEAR_W'(r_quot) * cdad_pkg::C_CYCLE_LEN);

    assign w_bad_in = (i_start_month < cdad_pkg::C_MONTH_JAN)
                   || (i_start_month > cdad_pkg::C_MONTH_DEC)
                   || (i_start_day == '0);
    assign w_sum    = cdad_pkg::ACC_W'(i_start_day) + cdad_pkg::ACC_W'(i_add_days);

    // The year modulo 400 is divisible by 4 exactly when the year is.
    assign w_leap = (r_ymod[1:0] == 2'b00)
                 && (r_ymod != cdad_pkg::C_YMOD_100)
                 && (r_ymod != cdad_pkg::C_YMOD_200)
                 && (r_ymod != cdad_pkg::C_YMOD_300);
    assign w_len  = cdad_pkg::f_month_len(r_month, w_leap);

    assign o_sts.done = r_bad || (r_day <= cdad_pkg::ACC_W'(w_len));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_start_year;
            r_month <= i_start_month;
            r_day   <= w_bad_in ? cdad_pkg::ACC_W'(i_start_day) : w_sum;
            r_bad   <= w_bad_in;
            r_quot  <= w_prod[cdad_pkg::C_DIV400_SHIFT +: cdad_pkg::QUOT_W];
        end else if (i_cmd.prep) begin
            r_ymod <= w_rem[cdad_pkg::YMOD_W-1:0];
        end else if (i_cmd.step) begin
            r_day <= r_day - cdad_pkg::ACC_W'(w_len);
            if (r_month == cdad_pkg::C_MONTH_DEC) begin
                r_month <= cdad_pkg::C_MONTH_JAN;
                r_year  <= r_year + cdad_pkg::YEAR_W'(1);
                // The year counter wraps to zero, which starts a fresh cycle.
                if (r_year == cdad_pkg::C_YEAR_MAX || r_ymod == cdad_pkg::C_YMOD_LAST) begin
                    r_ymod <= '0;
                end else begin
                    r_ymod <= r_ymod + cdad_pkg::YMOD_W'(1);
                end
            end else begin
                r_month <= r_month + cdad_pkg::MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_end_year  <= r_year;
            o_end_month <= r_month;
            o_end_day   <= r_day[cdad_pkg::DAY_W-1:0];
            o_bad_input <= r_bad;
        end
    end

endmodule

>>> hdl/calendar_date_add_days_core.sv
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds a day count to a Gregorian date and returns the resulting date.
// ----------------------------------------------------------------------------
// Usage: an item enters on the slave stream (i_s_*) with the start date and
// the day count in i_s_tdata. The result leaves on the master stream
// (o_m_*): the end date in o_m_tdata and the bad-input flag in o_m_tuser.
// A month of zero or above twelve, or a day of zero, sets the flag and the
// input date is echoed unchanged.
// The block works on one item at a time. The date is loaded at the accepting
// edge, the S_LOAD state then prepares the year-in-400 counter, and the month
// loop then steps once per month crossed (up to about 2160 for the largest
// count) and commits the result to the output register. A new item is taken
// in the cycle after the result is written into the output register, so the
// month loop sets how often items pass.
// When the receiver stalls the result waits in the output register; the
// next item is accepted and worked on, and holds in the loop until the
// register is free. Reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module calendar_date_add_days_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [13:0] start_year, [17:14] start_month, [22:18] start_day,
    // [38:23] add_days, [39] zero
    input  logic [cdad_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [13:0] end_year, [17:14] end_month, [22:18] end_day, [23] zero
    output logic [cdad_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] bad_input
    output logic [0:0]                       o_m_tuser
);

    cdad_pkg::t_cmd w_cmd;
    cdad_pkg::t_sts w_sts;

    logic [cdad_pkg::YEAR_W-1:0]  w_end_year;
    logic [cdad_pkg::MONTH_W-1:0] w_end_month;
    logic [cdad_pkg::DAY_W-1:0]   w_end_day;
    logic                         w_bad_input;

    cdad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cdad_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_start_year  (i_s_tdata[13:0]),
        .i_start_month (i_s_tdata[17:14]),
        .i_start_day   (i_s_tdata[22:18]),
        .i_add_days    (i_s_tdata[38:23]),
        .o_end_year    (w_end_year),
        .o_end_month   (w_end_month),
        .o_end_day     (w_end_day),
        .o_bad_input   (w_bad_input)
    );

    assign o_m_tdata = {1'b0, w_end_day, w_end_month, w_end_year};
    assign o_m_tuser = w_bad_input;

endmodule
